// ===== src/shtd_pkg.sv =====
// ----------------------------------------------------------------------------
// shtd_pkg
// shared types and constants for the static huffman tree decoder
// ----------------------------------------------------------------------------
`default_nettype none
package shtd_pkg;

  localparam int MAX_NODES = 512;
  localparam int NODE_W    = $clog2(MAX_NODES);
  localparam int NCNT_W    = $clog2(MAX_NODES + 1);

  typedef logic [NODE_W-1:0] node_t;

  // result status codes
  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_OVERFLOW = 2'd1,
    STAT_PREMATURE = 2'd2
  } status_t;

  // bit sequencer states
  typedef enum logic [2:0] {
    S_IDLE, S_BIT, S_POP, S_WLK1, S_WLK2, S_FIN
  } fsm_t;

  // stream phase
  typedef enum logic [1:0] {
    PH_TREE, PH_DECODE, PH_DONE
  } phase_t;

  // node memory access bundle
  typedef struct packed {
    logic  zc_we;
    node_t zc_waddr;
    logic  oc_we;
    node_t oc_waddr;
    node_t child_wdata;
    logic  lf_we;
    node_t lf_waddr;
    logic  lf_wdata;
    logic  ls_we;
    node_t ls_waddr;
    logic [7:0] ls_wdata;
    logic  st_we;
    node_t st_waddr;
    node_t st_wdata;
    node_t walk_raddr;
    node_t leaf_raddr;
    node_t st_raddr;
  } nm_req_t;

  typedef struct packed {
    node_t      zc_rdata;
    node_t      oc_rdata;
    logic       lf_rdata;
    logic [7:0] ls_rdata;
    node_t      st_rdata;
  } nm_rsp_t;

endpackage
`default_nettype wire

// ===== src/shtd_bitsrc.sv =====
// ----------------------------------------------------------------------------
// shtd_bitsrc
// byte shift register handing out one compressed bit per step, msb first
// ----------------------------------------------------------------------------
`default_nettype none
module shtd_bitsrc (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       load,
  input  wire logic [7:0] data,
  input  wire logic       shift,
  output logic            bit_out,
  output logic            last_bit
);
  logic [7:0] sh_r, sh_nxt;
  logic [3:0] left_r, left_nxt;

  always_comb begin
    sh_nxt   = sh_r;
    left_nxt = left_r;
    if (load) begin
      sh_nxt   = data;
      left_nxt = 4'd8;
    end else if (shift) begin
      sh_nxt   = {sh_r[6:0], 1'b0};
      left_nxt = left_r - 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r <= '0;
    end else begin
      left_r <= left_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sh_r <= sh_nxt;
  end

  assign bit_out  = sh_r[7];
  assign last_bit = (left_r == 4'd1);
endmodule
`default_nettype wire

// ===== src/shtd_nodemem.sv =====
// ----------------------------------------------------------------------------
// shtd_nodemem
// node pool (children, leaf flag, symbol) and open-node stack memories
// ----------------------------------------------------------------------------
`default_nettype none
module shtd_nodemem (
  input  wire logic             clk,
  input  wire shtd_pkg::nm_req_t req,
  output shtd_pkg::nm_rsp_t     rsp
);
  import shtd_pkg::*;

  node_t      zc_mem [MAX_NODES];
  node_t      oc_mem [MAX_NODES];
  logic       lf_mem [MAX_NODES];
  logic [7:0] ls_mem [MAX_NODES];
  node_t      st_mem [MAX_NODES];

  always_ff @(posedge clk) begin
    if (req.zc_we) zc_mem[req.zc_waddr] <= req.child_wdata;
    if (req.oc_we) oc_mem[req.oc_waddr] <= req.child_wdata;
    if (req.lf_we) lf_mem[req.lf_waddr] <= req.lf_wdata;
    if (req.ls_we) ls_mem[req.ls_waddr] <= req.ls_wdata;
    if (req.st_we) st_mem[req.st_waddr] <= req.st_wdata;
    rsp.zc_rdata <= zc_mem[req.walk_raddr];
    rsp.oc_rdata <= oc_mem[req.walk_raddr];
    rsp.lf_rdata <= lf_mem[req.leaf_raddr];
    rsp.ls_rdata <= ls_mem[req.leaf_raddr];
    rsp.st_rdata <= st_mem[req.st_raddr];
  end
endmodule
`default_nettype wire

// ===== src/static_huffman_tree_decoder.sv =====
// ----------------------------------------------------------------------------
// static_huffman_tree_decoder
// bit-serial huffman decoder with a pre-order serialised code tree
// ----------------------------------------------------------------------------
// Each input transaction carries one compressed byte, used msb first, one bit
// at a time through a shift register. The first bits rebuild the code tree in
// a 512-node memory using an explicit stack of open internal nodes; later bits
// walk the tree from the root and each leaf reached gives one result
// transaction. A node bit that closes an open node takes a stack read, then
// a child write, and a decode bit takes a child read, a leaf read, then an
// update, all set by the registered read ports of the node memory. The input
// stalls from the accept of a byte until its bits are used up or the stream
// ends inside it, and longer for a premature-end result or while the result
// register is stalled; a byte after the end is accepted without a stall.
// The stream ends on reaching output_length symbols, on a single-leaf tree
// (one result whose repeat_count is the whole length), on node pool
// overflow (status 1) or when a byte marked final runs out first (status 2);
// later bytes are then taken and ignored until reset. output_length may be
// written only while the block is idle.
`default_nettype none
module static_huffman_tree_decoder (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_final_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_symbol,
  output logic [31:0]      out_repeat_count,
  output logic             out_end_of_output,
  output logic [1:0]       out_status,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [31:0] cfg_output_length
);
  import shtd_pkg::*;

  fsm_t   state_r, state_nxt;
  phase_t phase_r, phase_nxt;

  logic [31:0]       len_r, len_nxt;
  logic [31:0]       prod_r, prod_nxt;
  logic [NCNT_W-1:0] nfn_r, nfn_nxt;      // next free node
  logic [NCNT_W-1:0] depth_r, depth_nxt;  // stack depth
  logic [NCNT_W-1:0] depth_base;
  node_t             walk_r, walk_nxt;
  node_t             child_r, child_nxt;
  node_t             child_sel;
  logic [7:0]        sym_sh_r, sym_sh_nxt;
  logic [7:0]        sym_new;
  logic [3:0]        sym_left_r, sym_left_nxt;
  logic              prev_leaf_r, prev_leaf_nxt;
  logic              root_leaf_r, root_leaf_nxt;
  logic              fin_r, fin_nxt;

  // result register
  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  o_sym_r, o_sym_nxt;
  logic [31:0] o_rep_r, o_rep_nxt;
  logic        o_end_r, o_end_nxt;
  status_t     o_st_r, o_st_nxt;
  logic        out_free;

  // bit source
  logic in_accept;
  logic cur_bit, last_bit, shift, do_alloc, next_bit;

  nm_req_t req;
  nm_rsp_t rsp;

  shtd_bitsrc u_bitsrc (
    .clk     (clk),
    .rst_n   (rst_n),
    .load    (in_accept),
    .data    (in_data_byte),
    .shift   (shift),
    .bit_out (cur_bit),
    .last_bit(last_bit)
  );

  shtd_nodemem u_nodemem (
    .clk(clk),
    .req(req),
    .rsp(rsp)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && (state_r == S_IDLE);
  assign cfg_ready = (state_r == S_IDLE);
  assign out_free  = !out_valid_r || !out_stall;
  assign child_sel = cur_bit ? rsp.oc_rdata : rsp.zc_rdata;
  assign sym_new   = {sym_sh_r[6:0], cur_bit};

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    len_nxt       = len_r;
    prod_nxt      = prod_r;
    nfn_nxt       = nfn_r;
    depth_nxt     = depth_r;
    depth_base    = depth_r;
    walk_nxt      = walk_r;
    child_nxt     = child_r;
    sym_sh_nxt    = sym_sh_r;
    sym_left_nxt  = sym_left_r;
    prev_leaf_nxt = prev_leaf_r;
    root_leaf_nxt = root_leaf_r;
    fin_nxt       = fin_r;
    out_valid_nxt = out_valid_r && out_stall;
    o_sym_nxt     = o_sym_r;
    o_rep_nxt     = o_rep_r;
    o_end_nxt     = o_end_r;
    o_st_nxt      = o_st_r;
    do_alloc      = 1'b0;
    next_bit      = 1'b0;
    shift         = 1'b0;

    req             = '0;
    req.child_wdata = nfn_r[NODE_W-1:0];
    req.st_wdata    = nfn_r[NODE_W-1:0];
    req.ls_wdata    = sym_new;
    req.ls_waddr    = node_t'(nfn_r - 1'b1);
    req.zc_waddr    = node_t'(nfn_r - 1'b1);
    req.oc_waddr    = rsp.st_rdata;
    req.lf_waddr    = nfn_r[NODE_W-1:0];
    req.lf_wdata    = cur_bit;
    req.walk_raddr  = walk_r;
    req.leaf_raddr  = child_sel;
    req.st_raddr    = node_t'(depth_r - 1'b1);

    if (cfg_valid && cfg_ready) len_nxt = cfg_output_length;

    unique case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          fin_nxt = in_final_byte;
          if (phase_r != PH_DONE) begin
            // a length written on the same edge applies to this byte
            if (len_nxt == 32'd0) phase_nxt = PH_DONE;
            else state_nxt = S_BIT;
          end
        end
      end
      S_BIT: begin
        priority if (phase_r == PH_DECODE) begin
          state_nxt = S_WLK1;
        end else if (sym_left_r != 4'd0) begin
          // symbol bits of a leaf
          if (sym_left_r == 4'd1 && depth_r == '0) begin
            // last leaf of the tree
            if (root_leaf_r) begin
              if (out_free) begin
                req.ls_we     = 1'b1;
                sym_sh_nxt    = sym_new;
                sym_left_nxt  = 4'd0;
                out_valid_nxt = 1'b1;
                o_sym_nxt     = sym_new;
                o_rep_nxt     = len_r;
                o_end_nxt     = 1'b1;
                o_st_nxt      = STAT_OK;
                phase_nxt     = PH_DONE;
                state_nxt     = S_IDLE;
              end
            end else begin
              req.ls_we    = 1'b1;
              sym_sh_nxt   = sym_new;
              sym_left_nxt = 4'd0;
              phase_nxt    = PH_DECODE;
              walk_nxt     = '0;
              next_bit     = 1'b1;
            end
          end else begin
            req.ls_we    = (sym_left_r == 4'd1);
            sym_sh_nxt   = sym_new;
            sym_left_nxt = sym_left_r - 4'd1;
            next_bit     = 1'b1;
          end
        end else if (nfn_r == NCNT_W'(MAX_NODES)) begin
          // node pool exhausted
          if (out_free) begin
            out_valid_nxt = 1'b1;
            o_sym_nxt     = 8'd0;
            o_rep_nxt     = 32'd0;
            o_end_nxt     = 1'b1;
            o_st_nxt      = STAT_OVERFLOW;
            phase_nxt     = PH_DONE;
            state_nxt     = S_IDLE;
          end
        end else if (nfn_r != '0 && prev_leaf_r && depth_r != '0) begin
          // close the open node on top of the stack first
          state_nxt = S_POP;
        end else begin
          req.zc_we = (nfn_r != '0) && !prev_leaf_r;
          do_alloc  = 1'b1;
          next_bit  = 1'b1;
        end
      end
      S_POP: begin
        req.oc_we  = 1'b1;
        depth_base = depth_r - 1'b1;
        depth_nxt  = depth_base;
        do_alloc   = 1'b1;
        next_bit   = 1'b1;
      end
      S_WLK1: begin
        child_nxt = child_sel;
        state_nxt = S_WLK2;
      end
      S_WLK2: begin
        if (rsp.lf_rdata) begin
          if (out_free) begin
            prod_nxt      = prod_r + 32'd1;
            out_valid_nxt = 1'b1;
            o_sym_nxt     = rsp.ls_rdata;
            o_rep_nxt     = 32'd1;
            o_end_nxt     = (prod_nxt >= len_r);
            o_st_nxt      = STAT_OK;
            walk_nxt      = '0;
            if (o_end_nxt) begin
              phase_nxt = PH_DONE;
              state_nxt = S_IDLE;
            end else begin
              next_bit = 1'b1;
            end
          end
        end else begin
          walk_nxt = child_r;
          next_bit = 1'b1;
        end
      end
      S_FIN: begin
        // final byte used up with the stream still open
        if (out_free) begin
          out_valid_nxt = 1'b1;
          o_sym_nxt     = 8'd0;
          o_rep_nxt     = 32'd0;
          o_end_nxt     = 1'b1;
          o_st_nxt      = STAT_PREMATURE;
          phase_nxt     = PH_DONE;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // new node at the next free slot
    if (do_alloc) begin
      req.lf_we     = 1'b1;
      prev_leaf_nxt = cur_bit;
      nfn_nxt       = nfn_r + 1'b1;
      if (nfn_r == '0) root_leaf_nxt = cur_bit;
      if (cur_bit) begin
        sym_sh_nxt   = 8'd0;
        sym_left_nxt = 4'd8;
      end else begin
        req.st_we    = 1'b1;
        req.st_waddr = depth_base[NODE_W-1:0];
        depth_nxt    = depth_base + 1'b1;
      end
    end

    if (next_bit) begin
      shift = 1'b1;
      if (last_bit) state_nxt = fin_r ? S_FIN : S_IDLE;
      else state_nxt = S_BIT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= PH_TREE;
      len_r       <= '0;
      prod_r      <= '0;
      nfn_r       <= '0;
      depth_r     <= '0;
      walk_r      <= '0;
      sym_sh_r    <= '0;
      sym_left_r  <= '0;
      prev_leaf_r <= 1'b0;
      root_leaf_r <= 1'b0;
      fin_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      len_r       <= len_nxt;
      prod_r      <= prod_nxt;
      nfn_r       <= nfn_nxt;
      depth_r     <= depth_nxt;
      walk_r      <= walk_nxt;
      sym_sh_r    <= sym_sh_nxt;
      sym_left_r  <= sym_left_nxt;
      prev_leaf_r <= prev_leaf_nxt;
      root_leaf_r <= root_leaf_nxt;
      fin_r       <= fin_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    child_r <= child_nxt;
    o_sym_r <= o_sym_nxt;
    o_rep_r <= o_rep_nxt;
    o_end_r <= o_end_nxt;
    o_st_r  <= o_st_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_symbol        = o_sym_r;
  assign out_repeat_count  = o_rep_r;
  assign out_end_of_output = o_end_r;
  assign out_status        = o_st_r;
endmodule
`default_nettype wire
